[rtl/core/assert_macros.svh]
// Assertion helpers shared by the lookup core modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside of reset.
`define IRL_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds at any clock edge outside of reset.
`define IRL_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[rtl/core/irl_pkg.sv]
`timescale 1ns / 1ps
package irl_pkg;

  localparam int IRL_MAX_ENTRIES = 64;
  localparam int IRL_CFG_W       = 7;
  localparam int IRL_SLOT_W      = 6;
  localparam int IRL_ID_W        = 16;
  localparam int IRL_VAL_W       = 32;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } irl_state_e;

  typedef struct packed {
    logic [IRL_ID_W-1:0]  id;
    logic [IRL_VAL_W-1:0] start;
    logic [IRL_VAL_W-1:0] length;
  } irl_entry_t;

  // Controller to datapath.
  typedef struct packed {
    logic cfg_we;
    logic wr_en;
    logic start;
    logic step;
    logic load_out;
  } irl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic skip;
    logic last;
    logic busy;
    logic out_free;
  } irl_sts_t;

endpackage

[rtl/core/irl_ctrl.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module irl_ctrl
  import irl_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     operation_i,
  input  logic     cfg_valid_i,
  input  irl_sts_t sts_i,
  output logic     in_stall_o,
  output logic     cfg_ready_o,
  output irl_cmd_t cmd_o
);

  irl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && (operation_i == OP_QUERY)) begin
          state_d = sts_i.skip ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts_i.last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // wait for the compare stages to empty
        if (!sts_i.busy) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o      = 1'b1;
    cfg_ready_o     = 1'b0;
    cmd_o           = '0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o     = 1'b0;
        cfg_ready_o    = 1'b1;
        cmd_o.cfg_we   = cfg_valid_i;
        cmd_o.wr_en    = in_valid_i && (operation_i == OP_WRITE);
        cmd_o.start    = in_valid_i && (operation_i == OP_QUERY);
      end
      ST_SCAN: begin
        cmd_o.step = 1'b1;
      end
      ST_DRAIN: begin
        cmd_o.step = 1'b0;
      end
      ST_FINISH: begin
        cmd_o.load_out = sts_i.out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  `IRL_ASSERT(a_skip_to_finish, clk_i, rst_ni, (cmd_o.start && sts_i.skip) |=> (state_q == ST_FINISH), "skipped query did not go straight to finish")
  `IRL_ASSERT(a_step_only_scan, clk_i, rst_ni, cmd_o.step |-> !cmd_o.start && !cmd_o.wr_en && in_stall_o, "scan step overlaps an accepted beat")
  `IRL_ASSERT_NEVER(a_load_while_busy, clk_i, rst_ni, cmd_o.load_out && sts_i.busy, "result loaded before compare stages drained")

endmodule

[rtl/core/irl_dpath.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module irl_dpath
  import irl_pkg::*;
#(
  parameter int MAX_ENTRIES = IRL_MAX_ENTRIES
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  irl_cmd_t                    cmd_i,
  input  logic [IRL_CFG_W-1:0]        entries_in_use_i,
  input  logic [IRL_SLOT_W-1:0]       slot_i,
  input  logic [IRL_ID_W-1:0]         entry_id_i,
  input  logic [IRL_VAL_W-1:0]        entry_start_i,
  input  logic [IRL_VAL_W-1:0]        entry_length_i,
  input  logic signed [IRL_VAL_W-1:0] query_offset_i,
  input  logic                        out_stall_i,
  output irl_sts_t                    sts_o,
  output logic                        out_valid_o,
  output logic                        found_o,
  output logic [IRL_ID_W-1:0]         region_id_o
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = (AW + 1 > IRL_CFG_W) ? AW + 1 : IRL_CFG_W;

  irl_entry_t mem [MAX_ENTRIES];

  logic [IRL_CFG_W-1:0] cfg_q;
  logic [CW-1:0]        n_cur;
  logic [CW-1:0]        n_q;
  logic [CW-1:0]        slot_ext;
  logic                 slot_ok;
  logic [AW-1:0]        addr_q;
  logic [IRL_VAL_W-1:0] off_q;

  irl_entry_t           rd_q;
  logic                 v1_q;
  logic [IRL_VAL_W-1:0] diff;
  logic                 hit1;

  logic                 v2_q;
  logic                 hit2_q;
  logic [IRL_VAL_W-1:0] len2_q;
  logic [IRL_ID_W-1:0]  id2_q;

  logic                 best_hit_q;
  logic [IRL_VAL_W-1:0] best_len_q;
  logic [IRL_ID_W-1:0]  best_id_q;

  logic                 out_valid_q;
  logic                 out_found_q;
  logic [IRL_ID_W-1:0]  out_id_q;

  // a count above the table depth scans the whole table
  assign n_cur = (CW'(cfg_q) > CW'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : CW'(cfg_q);
  assign slot_ext = CW'(slot_i);
  assign slot_ok  = slot_ext < CW'(MAX_ENTRIES);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cmd_i.cfg_we) begin
      cfg_q <= entries_in_use_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && slot_ok) begin
      mem[slot_ext[AW-1:0]] <= '{id: entry_id_i, start: entry_start_i, length: entry_length_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      rd_q <= mem[addr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      off_q <= IRL_VAL_W'(query_offset_i);
      n_q   <= n_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
    end else if (cmd_i.start) begin
      addr_q <= '0;
    end else if (cmd_i.step) begin
      addr_q <= addr_q + AW'(1);
    end
  end

  // containment test on the registered read beat
  assign diff = off_q - rd_q.start;
  assign hit1 = (off_q >= rd_q.start) && (diff < rd_q.length);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.step;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      hit2_q <= hit1;
      len2_q <= rd_q.length;
      id2_q  <= rd_q.id;
    end
  end

  // strictly smaller length replaces, so the earliest slot keeps a tie
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_hit_q <= 1'b0;
    end else if (cmd_i.start) begin
      best_hit_q <= 1'b0;
    end else if (v2_q && hit2_q) begin
      best_hit_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v2_q && hit2_q && (!best_hit_q || (len2_q < best_len_q))) begin
      best_len_q <= len2_q;
      best_id_q  <= id2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_found_q <= best_hit_q;
      out_id_q    <= best_hit_q ? best_id_q : '0;
    end
  end

  assign sts_o.skip     = query_offset_i[IRL_VAL_W-1] || (n_cur == '0);
  assign sts_o.last     = (CW'(addr_q) == (n_q - CW'(1)));
  assign sts_o.busy     = v1_q || v2_q;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign found_o     = out_found_q;
  assign region_id_o = out_id_q;

  `IRL_ASSERT(a_stage2_follows_read, clk_i, rst_ni, v2_q |-> $past(v1_q), "compare stage valid without a read beat")
  `IRL_ASSERT(a_miss_reports_zero, clk_i, rst_ni, (out_valid_q && !out_found_q) |-> (out_id_q == '0), "miss result carries a nonzero id")
  `IRL_ASSERT(a_load_sets_valid, clk_i, rst_ni, cmd_i.load_out |=> out_valid_q, "loaded result not presented")

endmodule

[rtl/core/innermost_region_lookup_core.sv]
`timescale 1ns / 1ps
// Region table lookup. A write beat (operation 0) stores id, start and length into one slot;
// slots at or above MAX_ENTRIES are dropped. A query beat (operation 1) scans slots 0 to n-1,
// n = min(entries_in_use, MAX_ENTRIES), through the table's single read port, one slot per cycle,
// followed by a two-stage compare, and returns the narrowest containing region (earliest slot on
// a tie). A query holds the input stalled while it scans, drains the compare stages and waits
// for the output register to be free; a query with a negative offset or n = 0 skips the scan. The
// result sits in an output register, so a new beat is taken while a finished result waits. Write
// entries_in_use only while the core is idle; reading a slot never written is undefined.
module innermost_region_lookup_core
  import irl_pkg::*;
#(
  parameter int MAX_ENTRIES = IRL_MAX_ENTRIES
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [IRL_CFG_W-1:0]        entries_in_use_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        operation_i,
  input  logic [IRL_SLOT_W-1:0]       slot_i,
  input  logic [IRL_ID_W-1:0]         entry_id_i,
  input  logic [IRL_VAL_W-1:0]        entry_start_i,
  input  logic [IRL_VAL_W-1:0]        entry_length_i,
  input  logic signed [IRL_VAL_W-1:0] query_offset_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        found_o,
  output logic [IRL_ID_W-1:0]         region_id_o
);

  irl_cmd_t cmd;
  irl_sts_t sts;

  irl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .operation_i (operation_i),
    .cfg_valid_i (cfg_valid_i),
    .sts_i       (sts),
    .in_stall_o  (in_stall_o),
    .cfg_ready_o (cfg_ready_o),
    .cmd_o       (cmd)
  );

  irl_dpath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .entries_in_use_i (entries_in_use_i),
    .slot_i           (slot_i),
    .entry_id_i       (entry_id_i),
    .entry_start_i    (entry_start_i),
    .entry_length_i   (entry_length_i),
    .query_offset_i   (query_offset_i),
    .out_stall_i      (out_stall_i),
    .sts_o            (sts),
    .out_valid_o      (out_valid_o),
    .found_o          (found_o),
    .region_id_o      (region_id_o)
  );

endmodule
